### src/fnorm_pkg.sv
package fnorm_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int INDEX_WIDTH_DEF = 24;
    localparam int NORM_BITS       = 24;
    localparam int UNIT_SHIFT      = 14;
    localparam int NORM_W          = 16;
    localparam int OUT_INDEX_W     = 24;
    localparam int QUEUE_DEPTH     = 2;
    localparam int SQRT_STEPS      = 25;
    localparam int DIV_STEPS       = 16;

    typedef enum logic [1:0] {
        MODE_LIST  = 2'd0,
        MODE_FAN   = 2'd1,
        MODE_STRIP = 2'd2,
        MODE_POLY  = 2'd3
    } t_prim_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CROSS,
        ST_NORM,
        ST_SQUARE,
        ST_SUM,
        ST_SQRT,
        ST_DINIT,
        ST_DIV,
        ST_DONE
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_flags;

    localparam logic [1:0] PHASE_ZERO  = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_TWO   = 2'd2;
    localparam logic [1:0] PHASE_THREE = 2'd3;

endpackage

### src/face_normal_generator_core.sv
// vertex side: one vertex request a cycle while the two-entry triangle queue has room
// normal side: the time from queue push to result valid is set by up to 23 one-bit normalize
// shifts, the 25-step square root and the 16-step divide; a degenerate triangle skips all three
// back end takes one triangle at a time from the queue; a full queue stalls the vertex side
// reset (synchronous, active low) clears assembly state, queue, mode and output valid
module face_normal_generator_core #(
    parameter int COORD_WIDTH = fnorm_pkg::COORD_WIDTH_DEF,
    parameter int INDEX_WIDTH = fnorm_pkg::INDEX_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // pos_x, pos_y, pos_z
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     i_s_tdata,
    // polygon_start
    input  logic                                   i_s_tuser,
    input  logic                                   i_s_tlast,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // norm_x, norm_y, norm_z, normal_index, degenerate
    output logic [79:0]                            o_m_tdata,
    input  logic                                   i_psel,
    input  logic                                   i_penable,
    input  logic                                   i_pwrite,
    input  logic [2:0]                             i_paddr,
    input  logic [31:0]                            i_pwdata,
    output logic [31:0]                            o_prdata,
    output logic                                   o_pready
);
    import fnorm_pkg::*;

    localparam int EW = 9 * COORD_WIDTH + INDEX_WIDTH;

    t_prim_mode              r_mode;
    t_queue_flags            qflags;
    logic                    push, pop;
    logic [EW-1:0]           push_entry, pop_entry;
    logic [NORM_W-1:0]       nx, ny, nz;
    logic [OUT_INDEX_W-1:0]  nidx;
    logic                    ndeg;

    assign o_pready = 1'b1;
    assign o_prdata = {30'd0, r_mode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LIST;
        end else if (i_psel && i_penable && i_pwrite && i_paddr == 3'd0) begin
            r_mode <= t_prim_mode'(i_pwdata[1:0]);
        end
    end

    fnorm_front #(.COORD_WIDTH(COORD_WIDTH), .INDEX_WIDTH(INDEX_WIDTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode   (r_mode),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_vertex (i_s_tdata[3*COORD_WIDTH-1:0]),
        .i_start  (i_s_tuser),
        .i_last   (i_s_tlast),
        .i_qflags (qflags),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    fnorm_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (pop_entry),
        .o_flags (qflags)
    );

    fnorm_back #(.COORD_WIDTH(COORD_WIDTH), .INDEX_WIDTH(INDEX_WIDTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qflags (qflags),
        .i_entry  (pop_entry),
        .o_pop    (pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_nx     (nx),
        .o_ny     (ny),
        .o_nz     (nz),
        .o_index  (nidx),
        .o_degen  (ndeg)
    );

    assign o_m_tdata = {7'd0, ndeg, nidx, nz, ny, nx};

endmodule

### src/fnorm_front.sv
module fnorm_front #(
    parameter int COORD_WIDTH = fnorm_pkg::COORD_WIDTH_DEF,
    parameter int INDEX_WIDTH = fnorm_pkg::INDEX_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fnorm_pkg::t_prim_mode      i_mode,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [3*COORD_WIDTH-1:0]   i_vertex,
    input  logic                       i_start,
    input  logic                       i_last,
    input  fnorm_pkg::t_queue_flags    i_qflags,
    output logic                       o_push,
    output logic [9*COORD_WIDTH+INDEX_WIDTH-1:0] o_entry
);
    import fnorm_pkg::*;

    localparam int VW = 3 * COORD_WIDTH;

    logic [VW-1:0]          r_fan, r_a, r_b;
    logic [1:0]             r_phase;
    logic [INDEX_WIDTH-1:0] r_cnt;

    logic [VW-1:0]          n_fan, n_a, n_b, ta, tb;
    logic [1:0]             n_phase, ph;
    logic [INDEX_WIDTH-1:0] n_cnt;
    logic                   emit, accept;

    assign o_ready = !i_qflags.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_fan   = r_fan;
        n_a     = r_a;
        n_b     = r_b;
        n_cnt   = r_cnt;
        ta      = r_a;
        tb      = r_b;
        emit    = 1'b0;
        ph      = r_phase;
        if (i_mode != MODE_POLY && ph == PHASE_THREE) begin
            ph = PHASE_ZERO;
        end
        if (i_mode == MODE_POLY && i_start) begin
            ph = PHASE_ZERO;
        end
        n_phase = ph;
        unique case (i_mode)
            MODE_LIST, MODE_POLY: begin
                unique case (ph)
                    PHASE_ZERO: begin
                        n_a = i_vertex;
                        n_phase = PHASE_ONE;
                    end
                    PHASE_ONE: begin
                        n_b = i_vertex;
                        n_phase = PHASE_TWO;
                    end
                    PHASE_TWO: begin
                        emit = 1'b1;
                        n_phase = (i_mode == MODE_POLY) ? PHASE_THREE : PHASE_ZERO;
                    end
                    default: begin
                        emit = 1'b0;
                    end
                endcase
            end
            MODE_FAN: begin
                if (ph == PHASE_ZERO) begin
                    n_fan = i_vertex;
                    n_phase = PHASE_ONE;
                end else if (ph == PHASE_ONE) begin
                    n_b = i_vertex;
                    n_phase = PHASE_TWO;
                end else begin
                    emit = 1'b1;
                    ta = r_fan;
                    n_b = i_vertex;
                end
            end
            default: begin
                if (ph == PHASE_ZERO) begin
                    n_a = i_vertex;
                    n_phase = PHASE_ONE;
                end else if (ph == PHASE_ONE) begin
                    n_b = i_vertex;
                    n_phase = PHASE_TWO;
                end else begin
                    emit = 1'b1;
                    // odd strip triangles swap winding
                    ta = r_cnt[0] ? r_b : r_a;
                    tb = r_cnt[0] ? r_a : r_b;
                    n_a = r_b;
                    n_b = i_vertex;
                end
            end
        endcase
        if (emit) begin
            n_cnt = r_cnt + 1'b1;
        end
        if (i_last) begin
            n_fan   = '0;
            n_a     = '0;
            n_b     = '0;
            n_phase = PHASE_ZERO;
            n_cnt   = '0;
        end
    end

    assign o_push  = accept && emit;
    assign o_entry = {r_cnt, i_vertex, tb, ta};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fan   <= '0;
            r_a     <= '0;
            r_b     <= '0;
            r_phase <= PHASE_ZERO;
            r_cnt   <= '0;
        end else if (accept) begin
            r_fan   <= n_fan;
            r_a     <= n_a;
            r_b     <= n_b;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### src/fnorm_queue.sv
module fnorm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = fnorm_pkg::QUEUE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [WIDTH-1:0]        i_data,
    input  logic                    i_pop,
    output logic [WIDTH-1:0]        o_data,
    output fnorm_pkg::t_queue_flags o_flags
);
    import fnorm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_flags.full  = (r_count == CW'(DEPTH));
    assign o_flags.empty = (r_count == '0);
    assign do_push = i_push && !o_flags.full;
    assign do_pop  = i_pop && !o_flags.empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/fnorm_back.sv
module fnorm_back #(
    parameter int COORD_WIDTH = fnorm_pkg::COORD_WIDTH_DEF,
    parameter int INDEX_WIDTH = fnorm_pkg::INDEX_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fnorm_pkg::t_queue_flags            i_qflags,
    input  logic [9*COORD_WIDTH+INDEX_WIDTH-1:0] i_entry,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [fnorm_pkg::NORM_W-1:0]       o_nx,
    output logic [fnorm_pkg::NORM_W-1:0]       o_ny,
    output logic [fnorm_pkg::NORM_W-1:0]       o_nz,
    output logic [fnorm_pkg::OUT_INDEX_W-1:0]  o_index,
    output logic                               o_degen
);
    import fnorm_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * DW;
    localparam int XW    = PW + 1;
    localparam int MAG_W = (XW > NORM_BITS + 1) ? XW : NORM_BITS + 1;
    localparam int SQ_W  = 2 * NORM_BITS;
    localparam int SUM_W = SQ_W + 2;
    localparam int LEN_W = SQRT_STEPS;
    localparam int REM_W = LEN_W + DIV_STEPS - 1;

    t_back_state r_state, n_state;

    logic signed [DW-1:0]   r_u [3];
    logic signed [DW-1:0]   r_w [3];
    logic signed [PW-1:0]   r_p [6];
    logic [MAG_W-1:0]       r_mag [3];
    logic                   r_neg [3];
    logic [SQ_W-1:0]        r_sq [3];
    logic [SUM_W-1:0]       r_s, r_root, r_bit;
    logic [REM_W-1:0]       r_rem [3];
    logic [REM_W-1:0]       r_div;
    logic [NORM_W-1:0]      r_q [3];
    logic [4:0]             r_cnt;
    logic                   r_degen;
    logic [INDEX_WIDTH-1:0] r_idx;

    logic [MAG_W-1:0]       mag_or;
    logic                   load_out, sq_take;
    logic [SUM_W-1:0]       trial;

    function automatic logic signed [DW-1:0] coord(input logic [9*CW+INDEX_WIDTH-1:0] e,
                                                   input int v, input int k);
        logic [CW-1:0] c;
        c = e[(3*v+k)*CW +: CW];
        return DW'($signed(c));
    endfunction

    function automatic logic [NORM_W-1:0] apply_sign(input logic [NORM_W-1:0] q,
                                                     input logic neg);
        return neg ? (~q + 1'b1) : q;
    endfunction

    assign mag_or   = r_mag[0] | r_mag[1] | r_mag[2];
    assign load_out = (r_state == ST_DONE) && (!o_valid || i_ready);
    assign o_pop    = (r_state == ST_IDLE) && !i_qflags.empty;
    assign trial    = r_root + r_bit;
    assign sq_take  = (r_s >= trial);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (!i_qflags.empty) n_state = ST_MUL;
            ST_MUL:    n_state = ST_CROSS;
            ST_CROSS:  n_state = ST_NORM;
            ST_NORM: begin
                if (mag_or == '0) begin
                    n_state = ST_DONE;
                end else if (mag_or[MAG_W-1:NORM_BITS] == '0 && mag_or[NORM_BITS-1]) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: n_state = ST_SUM;
            ST_SUM:    n_state = ST_SQRT;
            ST_SQRT:   if (r_cnt == '0) n_state = ST_DINIT;
            ST_DINIT:  n_state = ST_DIV;
            ST_DIV:    if (r_cnt == '0) n_state = ST_DONE;
            ST_DONE:   if (load_out) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                for (int k = 0; k < 3; k++) begin
                    r_u[k] <= coord(i_entry, 1, k) - coord(i_entry, 0, k);
                    r_w[k] <= coord(i_entry, 2, k) - coord(i_entry, 1, k);
                end
                r_idx   <= i_entry[9*CW +: INDEX_WIDTH];
                r_degen <= 1'b0;
            end
            ST_MUL: begin
                r_p[0] <= r_u[1] * r_w[2];
                r_p[1] <= r_u[2] * r_w[1];
                r_p[2] <= r_u[2] * r_w[0];
                r_p[3] <= r_u[0] * r_w[2];
                r_p[4] <= r_u[0] * r_w[1];
                r_p[5] <= r_u[1] * r_w[0];
            end
            ST_CROSS: begin
                for (int k = 0; k < 3; k++) begin
                    logic signed [XW-1:0] x;
                    x = XW'(r_p[2*k]) - XW'(r_p[2*k+1]);
                    r_neg[k] <= x[XW-1];
                    r_mag[k] <= MAG_W'(x[XW-1] ? -x : x);
                end
            end
            ST_NORM: begin
                // shift all three by one bit until the top one lands on bit 23
                if (mag_or == '0) begin
                    r_degen <= 1'b1;
                    for (int k = 0; k < 3; k++) r_q[k] <= '0;
                end else if (mag_or[MAG_W-1:NORM_BITS] != '0) begin
                    for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] >> 1;
                end else if (!mag_or[NORM_BITS-1]) begin
                    for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] << 1;
                end
            end
            ST_SQUARE: begin
                for (int k = 0; k < 3; k++) begin
                    r_sq[k] <= r_mag[k][NORM_BITS-1:0] * r_mag[k][NORM_BITS-1:0];
                end
            end
            ST_SUM: begin
                r_s    <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
                r_root <= '0;
                r_bit  <= SUM_W'(1) << (2 * (SQRT_STEPS - 1));
                r_cnt  <= 5'(SQRT_STEPS - 1);
            end
            ST_SQRT: begin
                if (sq_take) begin
                    r_s    <= r_s - trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 1'b1;
            end
            ST_DINIT: begin
                for (int k = 0; k < 3; k++) begin
                    r_rem[k] <= (REM_W'(r_mag[k][NORM_BITS-1:0]) << UNIT_SHIFT)
                              + REM_W'(r_root[LEN_W-1:1]);
                    r_q[k]   <= '0;
                end
                r_div <= REM_W'(r_root[LEN_W-1:0]) << (DIV_STEPS - 1);
                r_cnt <= 5'(DIV_STEPS - 1);
            end
            ST_DIV: begin
                for (int k = 0; k < 3; k++) begin
                    if (r_rem[k] >= r_div) begin
                        r_rem[k] <= r_rem[k] - r_div;
                        r_q[k]   <= {r_q[k][NORM_W-2:0], 1'b1};
                    end else begin
                        r_q[k]   <= {r_q[k][NORM_W-2:0], 1'b0};
                    end
                end
                r_div <= r_div >> 1;
                r_cnt <= r_cnt - 1'b1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_nx    <= apply_sign(r_q[0], r_neg[0]);
            o_ny    <= apply_sign(r_q[1], r_neg[1]);
            o_nz    <= apply_sign(r_q[2], r_neg[2]);
            o_index <= OUT_INDEX_W'(r_idx);
            o_degen <= r_degen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (load_out) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

endmodule

### src/fnorm_checker.sv
module fnorm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [79:0] o_m_tdata,
    input logic        o_pready
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[72] |-> o_m_tdata[47:0] == 48'd0)
        else $error("degenerate normal not zero");

    a_normal_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[72] |-> o_m_tdata[47:0] != 48'd0)
        else $error("unit normal came out zero");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pready)
        else $error("config port not ready");

endmodule

bind face_normal_generator_core fnorm_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_pready   (o_pready)
);
